### rtl/bna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bna_pkg
// Shared widths, defaults and status codes for the batch-norm inference block.
// ----------------------------------------------------------------------------
package bna_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int DATA_W            = 32;
  localparam int VAR_W             = 31;
  localparam int EPS_W             = 16;
  localparam int STATUS_W          = 2;
  localparam int CFG_IDX_W         = 1;

  // in_tdata: activation, mean, variance, scale, offset, padded to bytes
  localparam int IN_TDATA_W  = 160;
  // out_tdata: normalized, status, padded to bytes
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZDIV = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPSILON = 1'b0,
    REG_AFFINE  = 1'b1
  } cfg_reg_t;

endpackage : bna_pkg
`default_nettype wire

### rtl/bna_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bna_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bna_sqrt #(
  parameter int SQ = 24,
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*SQ-1:0]   in_rad,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [SQ-1:0]          out_root,
  output logic [SW-1:0]          out_side
);
  import bna_pkg::*;

  localparam int RADW = 2 * SQ;

  logic            v_r    [SQ];
  logic [SQ-1:0]   rem_r  [SQ];
  logic [SQ-1:0]   root_r [SQ];
  logic [RADW-1:0] rad_r  [SQ];
  logic [SW-1:0]   side_r [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_stage
    logic            pv;
    logic [SQ-1:0]   prem;
    logic [SQ-1:0]   proot;
    logic [RADW-1:0] prad;
    logic [SW-1:0]   pside;
    logic [SQ+1:0]   trem;
    logic [SQ+1:0]   trial;
    logic [SQ-1:0]   rem_nxt;
    logic [SQ-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign prad  = rad_r[k-1];
      assign pside = side_r[k-1];
    end

    always_comb begin
      trem  = {prem, prad[RADW-1 -: 2]};
      trial = {proot, 2'b01};
      if (trem >= trial) begin
        rem_nxt  = SQ'(trem - trial);
        root_nxt = {proot[SQ-2:0], 1'b1};
      end else begin
        rem_nxt  = SQ'(trem);
        root_nxt = {proot[SQ-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= {prad[RADW-3:0], 2'b00};
        side_r[k] <= pside;
      end
    end
  end

  assign out_valid = v_r[SQ-1];
  assign out_root  = root_r[SQ-1];
  assign out_side  = side_r[SQ-1];

endmodule : bna_sqrt
`default_nettype wire

### rtl/bna_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bna_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bna_div #(
  parameter int DW = 49,
  parameter int QW = 24,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [DW-1:0]   in_dividend,
  input  wire logic [QW-1:0]   in_divisor,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_valid,
  output logic [DW-1:0]        out_quot,
  output logic [SW-1:0]        out_side
);
  import bna_pkg::*;

  logic          v_r    [DW];
  logic [QW-1:0] rem_r  [DW];
  logic [DW-1:0] num_r  [DW];
  logic [DW-1:0] quot_r [DW];
  logic [QW-1:0] den_r  [DW];
  logic [SW-1:0] side_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          pv;
    logic [QW-1:0] prem;
    logic [DW-1:0] pnum;
    logic [DW-1:0] pquot;
    logic [QW-1:0] pden;
    logic [SW-1:0] pside;
    logic [QW:0]   trem;
    logic [QW-1:0] rem_nxt;
    logic          qbit;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign pnum  = in_dividend;
      assign pquot = '0;
      assign pden  = in_divisor;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign pnum  = num_r[k-1];
      assign pquot = quot_r[k-1];
      assign pden  = den_r[k-1];
      assign pside = side_r[k-1];
    end

    always_comb begin
      trem = {prem, pnum[DW-1]};
      qbit = (trem >= {1'b0, pden});
      if (qbit) begin
        rem_nxt = QW'(trem - {1'b0, pden});
      end else begin
        rem_nxt = QW'(trem);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= {pnum[DW-2:0], 1'b0};
        quot_r[k] <= {pquot[DW-2:0], qbit};
        den_r[k]  <= pden;
        side_r[k] <= pside;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_quot  = quot_r[DW-1];
  assign out_side  = side_r[DW-1];

endmodule : bna_div
`default_nettype wire

### rtl/bna_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bna_post
// Norm saturation, scale multiply, floor shift, offset add and output register.
// ----------------------------------------------------------------------------
module bna_post #(
  parameter int DW            = 49,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          affine,
  input  wire logic                          in_valid,
  input  wire logic [DW-1:0]                 in_quot,
  input  wire logic                          in_neg,
  input  wire logic                          in_dz,
  input  wire logic                          in_zdiv,
  input  wire logic signed [bna_pkg::DATA_W-1:0] in_scale,
  input  wire logic signed [bna_pkg::DATA_W-1:0] in_offset,
  output logic                               out_valid,
  output logic signed [bna_pkg::DATA_W-1:0]  out_norm,
  output bna_pkg::status_t                   out_status
);
  import bna_pkg::*;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DW-1:0] Q_POS_LIM = DW'(S_MAX);
  localparam logic [DW-1:0] Q_NEG_LIM = DW'({1'b0, S_MIN});

  // stage A: saturated norm, zero-divisor value
  logic                     a_v_r;
  logic signed [DATA_W-1:0] a_norm_r, a_norm_nxt;
  logic                     a_sat_r, a_sat_nxt;
  logic                     a_zdiv_r;
  logic signed [DATA_W-1:0] a_zval_r, a_zval_nxt;
  logic signed [DATA_W-1:0] a_scale_r, a_offset_r;

  always_comb begin
    logic zsign_neg;
    logic zsign_zero;
    if (in_neg) begin
      a_sat_nxt  = (in_quot > Q_NEG_LIM);
      a_norm_nxt = a_sat_nxt ? S_MIN : DATA_W'(-in_quot[DATA_W-1:0]);
    end else begin
      a_sat_nxt  = (in_quot > Q_POS_LIM);
      a_norm_nxt = a_sat_nxt ? S_MAX : DATA_W'(in_quot[DATA_W-1:0]);
    end
    zsign_neg  = in_neg ^ (affine & in_scale[DATA_W-1]);
    zsign_zero = in_dz | (affine & (in_scale == '0));
    a_zval_nxt = zsign_zero ? '0 : (zsign_neg ? S_MIN : S_MAX);
  end

  // stage B: product
  logic                       b_v_r;
  logic signed [2*DATA_W-1:0] b_prod_r;
  logic signed [DATA_W-1:0]   b_norm_r, b_zval_r, b_offset_r;
  logic                       b_sat_r, b_zdiv_r;

  // stage C: output register
  logic                     c_v_r;
  logic signed [DATA_W-1:0] c_norm_r, c_norm_nxt;
  status_t                  c_status_r, c_status_nxt;

  always_comb begin
    logic signed [2*DATA_W-1:0] sh;
    logic signed [2*DATA_W:0]   sum;
    logic                       sat;
    sh  = b_prod_r >>> FRACTION_BITS;
    sum = (2*DATA_W+1)'(sh) + (2*DATA_W+1)'(b_offset_r);
    sat = b_sat_r;
    if (b_zdiv_r) begin
      c_norm_nxt = b_zval_r;
    end else if (affine) begin
      if (sum > (2*DATA_W+1)'(S_MAX)) begin
        c_norm_nxt = S_MAX;
        sat        = 1'b1;
      end else if (sum < (2*DATA_W+1)'(S_MIN)) begin
        c_norm_nxt = S_MIN;
        sat        = 1'b1;
      end else begin
        c_norm_nxt = DATA_W'(sum);
      end
    end else begin
      c_norm_nxt = b_norm_r;
    end
    if (b_zdiv_r) begin
      c_status_nxt = ST_ZDIV;
    end else if (sat) begin
      c_status_nxt = ST_SAT;
    end else begin
      c_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_norm_r   <= a_norm_nxt;
      a_sat_r    <= a_sat_nxt;
      a_zdiv_r   <= in_zdiv;
      a_zval_r   <= a_zval_nxt;
      a_scale_r  <= in_scale;
      a_offset_r <= in_offset;
      b_prod_r   <= a_norm_r * a_scale_r;
      b_norm_r   <= a_norm_r;
      b_zval_r   <= a_zval_r;
      b_offset_r <= a_offset_r;
      b_sat_r    <= a_sat_r;
      b_zdiv_r   <= a_zdiv_r;
      c_norm_r   <= c_norm_nxt;
      c_status_r <= c_status_nxt;
    end
  end

  assign out_valid  = c_v_r;
  assign out_norm   = c_norm_r;
  assign out_status = c_status_r;

endmodule : bna_post
`default_nettype wire

### rtl/batchnorm_affine_inference.sv
`default_nettype none
// ----------------------------------------------------------------------------
// batchnorm_affine_inference
// Batch normalisation, inference form, signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one transfer carries activation, channel mean, variance, scale
//    and offset. out_*: one transfer per input item, normalised value plus
//    a status code (ok, saturated, zero divisor), in input order.
//  - cfg_*: epsilon and affine enable; write only while the block is empty.
//  - Throughput: one item per cycle while the output is not stalled. An
//    input transfer passes the stage 0 register, SQ = ceil((32+F)/2) root
//    stages, DW = 33+F divider stages and post stages A, B and C before
//    out_tvalid; root and divider pipelines resolve one bit per stage.
//  - Stall: the whole pipeline holds while out_tvalid is high and
//    out_tready low; nothing is lost or repeated. in_tready falls then.
//  - Reset: all stage valid bits cleared, epsilon = 1, affine enable = 1.
// ----------------------------------------------------------------------------
module batchnorm_affine_inference #(
  parameter int FRACTION_BITS = bna_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // activation[31:0], mean[63:32], variance[94:64], scale[126:95],
  // offset[158:127], zero pad[159]
  input  wire logic [bna_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // normalized[31:0], status[33:32], zero pad[39:34]
  output logic [bna_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bna_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bna_pkg::EPS_W-1:0]         cfg_wr_data
);
  import bna_pkg::*;

  localparam int SQ   = (DATA_W + FRACTION_BITS + 1) / 2;
  localparam int DW   = DATA_W + 1 + FRACTION_BITS;
  localparam int SW_S = 2 + (DATA_W + 1) + 2 * DATA_W;
  localparam int SW_D = 2 + 2 * DATA_W;

  // configuration
  logic [EPS_W-1:0] eps_r;
  logic             aff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
      aff_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EPSILON: eps_r <= cfg_wr_data;
        REG_AFFINE:  aff_r <= cfg_wr_data[0];
        default:     ;
      endcase
    end
  end

  // global advance: pipeline moves unless the output transfer is stalled
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: difference and variance sum
  logic signed [DATA_W-1:0] x_in, m_in, g_in, b_in;
  logic [VAR_W-1:0]         var_in;
  assign x_in   = in_tdata[31:0];
  assign m_in   = in_tdata[63:32];
  assign var_in = in_tdata[94:64];
  assign g_in   = in_tdata[126:95];
  assign b_in   = in_tdata[158:127];

  logic                     s0_v_r;
  logic [DATA_W-1:0]        s0_sum_r;
  logic                     s0_neg_r, s0_dz_r;
  logic [DATA_W:0]          s0_mag_r;
  logic signed [DATA_W-1:0] s0_g_r, s0_b_r;

  logic signed [DATA_W:0] diff;
  assign diff = (DATA_W+1)'(x_in) - (DATA_W+1)'(m_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sum_r <= DATA_W'(var_in) + DATA_W'(eps_r);
      s0_neg_r <= diff[DATA_W];
      s0_dz_r  <= (diff == '0);
      s0_mag_r <= diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
      s0_g_r   <= g_in;
      s0_b_r   <= b_in;
    end
  end

  // square root of (variance + epsilon) << F
  logic            sq_v;
  logic [SQ-1:0]   sq_root;
  logic [SW_S-1:0] sq_side;

  bna_sqrt #(.SQ(SQ), .SW(SW_S)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_rad    ((2*SQ)'({s0_sum_r, {FRACTION_BITS{1'b0}}})),
    .in_side   ({s0_neg_r, s0_dz_r, s0_mag_r, s0_g_r, s0_b_r}),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                     sq_neg, sq_dz;
  logic [DATA_W:0]          sq_mag;
  logic [2*DATA_W-1:0]      sq_gb;
  assign {sq_neg, sq_dz, sq_mag, sq_gb} = sq_side;

  // |diff| << F divided by the root
  logic            dv_v;
  logic [DW-1:0]   dv_quot;
  logic [SW_D-1:0] dv_side;

  bna_div #(.DW(DW), .QW(SQ), .SW(SW_D)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (sq_v),
    .in_dividend ({sq_mag, {FRACTION_BITS{1'b0}}}),
    .in_divisor  (sq_root),
    .in_side     ({sq_neg, sq_dz, sq_gb}),
    .out_valid   (dv_v),
    .out_quot    (dv_quot),
    .out_side    (dv_side)
  );

  // the root is zero only when variance + epsilon is zero; flag rides along
  // in a matching delay line beside the divider
  logic zd_r [DW];
  for (genvar k = 0; k < DW; k++) begin : g_zd
    if (k == 0) begin : g_first
      always_ff @(posedge clk) if (en) zd_r[k] <= (sq_root == '0);
    end else begin : g_next
      always_ff @(posedge clk) if (en) zd_r[k] <= zd_r[k-1];
    end
  end

  logic                     dv_neg, dv_dz;
  logic signed [DATA_W-1:0] dv_g, dv_b;
  assign {dv_neg, dv_dz, dv_g, dv_b} = dv_side;

  logic                     pst_v;
  logic signed [DATA_W-1:0] pst_norm;
  status_t                  pst_status;

  bna_post #(.DW(DW), .FRACTION_BITS(FRACTION_BITS)) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .affine     (aff_r),
    .in_valid   (dv_v),
    .in_quot    (dv_quot),
    .in_neg     (dv_neg),
    .in_dz      (dv_dz),
    .in_zdiv    (zd_r[DW-1]),
    .in_scale   (dv_g),
    .in_offset  (dv_b),
    .out_valid  (pst_v),
    .out_norm   (pst_norm),
    .out_status (pst_status)
  );

  assign out_tvalid = pst_v;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-STATUS_W){1'b0}}, pst_status, pst_norm};

  // assertions
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_zdiv_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pst_status == ST_ZDIV |->
      pst_norm == '0 || pst_norm == {1'b0, {(DATA_W-1){1'b1}}} ||
      pst_norm == {1'b1, {(DATA_W-1){1'b0}}})
    else $error("zero-divisor result not saturated or zero");

  a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline stalled");

endmodule : batchnorm_affine_inference
`default_nettype wire
